// File: sv/hlct_pkg.sv
package hlct_pkg;
    localparam int AlphabetSize = 26;
    localparam int LetterBits   = 5;
    localparam int CountBits    = 20;
    localparam int SumBits      = 25;
    localparam int ProbBits     = 16;
    localparam int CellBits     = 10;
    localparam int Cells        = AlphabetSize * AlphabetSize;

    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    typedef enum logic [1:0] {
        TABLE_EMIT  = 2'd0,
        TABLE_TRANS = 2'd1,
        TABLE_DIST  = 2'd2,
        TABLE_NONE  = 2'd3
    } t_table;

    typedef struct packed {
        logic                  req_type;
        logic [LetterBits-1:0] clean_letter;
        logic [LetterBits-1:0] noisy_letter;
        logic                  word_start;
        logic [1:0]            table_select;
        logic [LetterBits-1:0] row_letter;
        logic [LetterBits-1:0] col_letter;
    } t_req;

    typedef struct packed {
        logic [ProbBits-1:0] probability;
        logic                is_read_result;
        logic                count_saturated;
    } t_rsp;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic                  is_read;
        logic                  train_ok;
        logic                  do_trans;
        logic                  read_ok;
        t_table                tbl;
        logic [LetterBits-1:0] clean;
        logic [LetterBits-1:0] noisy;
        logic [LetterBits-1:0] prev;
        logic [LetterBits-1:0] row;
        logic [LetterBits-1:0] col;
    } t_cmd;

    function automatic logic [CellBits-1:0] cell_addr(
        input logic [LetterBits-1:0] r, input logic [LetterBits-1:0] c);
        logic [CellBits+LetterBits-1:0] p;
        p = (CellBits+LetterBits)'(r) * (CellBits+LetterBits)'(AlphabetSize)
            + (CellBits+LetterBits)'(c);
        return p[CellBits-1:0];
    endfunction
endpackage

// File: sv/hlct_if.sv
interface hlct_req_if;
    import hlct_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface hlct_rsp_if;
    import hlct_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: sv/hlct_ram.sv
module hlct_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/hlct_front.sv
module hlct_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hlct_req_if.sink      req,
    output logic          o_push,
    output hlct_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import hlct_pkg::*;

    logic [LetterBits-1:0] r_prev;
    logic                  r_prev_ok;
    logic                  tr_ok;

    assign req.ready = !i_full;
    assign o_push    = req.valid && !i_full;
    assign tr_ok = (req.data.clean_letter < LetterBits'(AlphabetSize))
                && (req.data.noisy_letter < LetterBits'(AlphabetSize));

    always_comb begin
        o_cmd          = '0;
        o_cmd.is_read  = req.data.req_type;
        o_cmd.train_ok = !req.data.req_type && tr_ok;
        o_cmd.do_trans = !req.data.req_type && tr_ok && !req.data.word_start && r_prev_ok;
        o_cmd.tbl      = t_table'(req.data.table_select);
        o_cmd.clean    = req.data.clean_letter;
        o_cmd.noisy    = req.data.noisy_letter;
        o_cmd.prev     = r_prev;
        o_cmd.row      = req.data.row_letter;
        o_cmd.col      = req.data.col_letter;
        unique case (t_table'(req.data.table_select))
            TABLE_EMIT, TABLE_TRANS: begin
                o_cmd.read_ok = (req.data.row_letter < LetterBits'(AlphabetSize))
                             && (req.data.col_letter < LetterBits'(AlphabetSize));
            end
            TABLE_DIST: o_cmd.read_ok = req.data.col_letter < LetterBits'(AlphabetSize);
            default:    o_cmd.read_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_prev_ok <= 1'b0;
        end else if (o_push && o_cmd.train_ok) begin
            r_prev    <= req.data.clean_letter;
            r_prev_ok <= 1'b1;
        end
    end
endmodule

// File: sv/hlct_fifo.sv
module hlct_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hlct_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output hlct_pkg::t_cmd o_cmd
);
    import hlct_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// File: sv/hlct_back.sv
module hlct_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  hlct_pkg::t_cmd i_cmd,
    output logic           o_pop,
    hlct_rsp_if.source     rsp
);
    import hlct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_WRITE = 6'b000100,
        S_DIV   = 6'b001000,
        S_DONE  = 6'b010000,
        S_CLEAR = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [CellBits-1:0]   r_clr;
    logic [SumBits-1:0]    r_esum [AlphabetSize];
    logic [SumBits-1:0]    r_tsum [AlphabetSize];
    logic [CountBits-1:0]  r_lcnt [AlphabetSize];
    logic [SumBits-1:0]    r_total;
    logic [SumBits:0]      r_rem;
    logic [SumBits-1:0]    r_den;
    logic [ProbBits-1:0]   r_q;
    logic [$clog2(ProbBits+1)-1:0] r_step;
    logic                  r_zero;
    logic                  r_sat;
    logic                  r_ovalid;
    t_rsp                  r_odata;

    logic                 e_we, t_we;
    logic [CellBits-1:0]  e_wa, t_wa, e_ra, t_ra;
    logic [CountBits-1:0] e_wd, t_wd, e_rd, t_rd;

    hlct_ram #(.Width(CountBits), .Depth(Cells)) u_emit (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));
    hlct_ram #(.Width(CountBits), .Depth(Cells)) u_trans (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd));

    logic [CellBits-1:0] emit_cell, trans_cell;
    assign emit_cell  = r_cmd.is_read ? cell_addr(r_cmd.row, r_cmd.col)
                                      : cell_addr(r_cmd.clean, r_cmd.noisy);
    assign trans_cell = r_cmd.is_read ? cell_addr(r_cmd.row, r_cmd.col)
                                      : cell_addr(r_cmd.prev, r_cmd.clean);
    assign e_ra = emit_cell;
    assign t_ra = trans_cell;

    logic e_full, t_full, l_full;
    logic [CountBits-1:0] lc;
    assign lc     = r_lcnt[r_cmd.clean];
    assign e_full = e_rd == CountMax;
    assign t_full = t_rd == CountMax;
    assign l_full = lc == CountMax;

    always_comb begin
        e_we = 1'b0;
        t_we = 1'b0;
        e_wa = emit_cell;
        t_wa = trans_cell;
        e_wd = e_rd + CountBits'(1);
        t_wd = t_rd + CountBits'(1);
        if (r_state == S_CLEAR) begin
            e_we = 1'b1;
            t_we = 1'b1;
            e_wa = r_clr;
            t_wa = r_clr;
            e_wd = '0;
            t_wd = '0;
        end else if (r_state == S_WRITE) begin
            e_we = r_cmd.train_ok && !e_full;
            t_we = r_cmd.do_trans && !t_full;
        end
    end

    // Numerator and denominator picked once the counts are back from the RAMs.
    logic [SumBits-1:0] num, den;
    always_comb begin
        num = '0;
        den = '0;
        unique case (r_cmd.tbl)
            TABLE_EMIT: begin
                num = (e_rd == '0) ? SumBits'(1) : SumBits'(e_rd);
                den = r_esum[r_cmd.row];
            end
            TABLE_TRANS: begin
                num = (t_rd == '0) ? SumBits'(1) : SumBits'(t_rd);
                den = r_tsum[r_cmd.row];
            end
            TABLE_DIST: begin
                num = SumBits'(r_lcnt[r_cmd.col]);
                den = r_total;
            end
            default: ;
        endcase
    end

    logic [SumBits:0] rem2;
    logic             ge;
    assign rem2 = {r_rem[SumBits-1:0], 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign rsp.valid = r_ovalid;
    assign rsp.data  = r_odata;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == CellBits'(Cells - 1)) n_state = S_IDLE;
            S_IDLE:  if (o_pop) n_state = S_FETCH;
            S_FETCH: n_state = r_cmd.is_read ? S_DIV : S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DIV:   if (r_step == ($clog2(ProbBits+1))'(ProbBits)) n_state = S_DONE;
            S_DONE:  if (!r_ovalid || rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_total  <= '0;
            for (int i = 0; i < AlphabetSize; i++) begin
                r_esum[i] <= SumBits'(AlphabetSize);
                r_tsum[i] <= SumBits'(AlphabetSize);
                r_lcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_ovalid || rsp.ready)) r_ovalid <= 1'b1;
            else if (rsp.ready)                                r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + CellBits'(1);
                S_WRITE: begin
                    if (r_cmd.train_ok) begin
                        if (!e_full && e_rd != '0)
                            r_esum[r_cmd.clean] <= r_esum[r_cmd.clean] + SumBits'(1);
                        if (!l_full) begin
                            r_lcnt[r_cmd.clean] <= lc + CountBits'(1);
                            r_total <= r_total + SumBits'(1);
                        end
                    end
                    if (r_cmd.do_trans && !t_full && t_rd != '0)
                        r_tsum[r_cmd.prev] <= r_tsum[r_cmd.prev] + SumBits'(1);
                    r_sat <= r_cmd.train_ok &&
                             (e_full || l_full || (r_cmd.do_trans && t_full));
                end
                S_FETCH: ;
                S_DIV: begin
                    if (r_step == '0) begin
                        r_den <= den;
                        r_rem <= {1'b0, num};
                        r_q   <= '0;
                        r_zero <= !r_cmd.read_ok || den == '0;
                        r_sat  <= num >= den;
                    end else begin
                        r_q   <= {r_q[ProbBits-2:0], ge};
                        r_rem <= ge ? rem2 - {1'b0, r_den} : rem2;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || rsp.ready) begin
                        r_odata.is_read_result  <= r_cmd.is_read;
                        r_odata.count_saturated <= !r_cmd.is_read && r_sat;
                        r_odata.probability <= !r_cmd.is_read || r_zero ? '0 :
                                               r_sat ? {ProbBits{1'b1}} : r_q;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_DIV) r_step <= r_step + 1'b1;
        else                  r_step <= '0;
    end
endmodule

// File: sv/hmm_letter_count_trainer_core.sv
// Path: train words go from queue to output through FETCH, WRITE and DONE; reads
// go through FETCH, DIV (16-step restoring divider) and DONE. The back end
// serves one word at a time and pops no new word until the last one is done.
// Reset: synchronous active low; then a clearing pass over 676 cells zeroes both
// count RAMs, during which no word is accepted once the 2-entry queue is full.
module hmm_letter_count_trainer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlct_req_if.sink   req,
    hlct_rsp_if.source rsp
);
    import hlct_pkg::*;

    logic push, full, pop, empty;
    t_cmd f_cmd, b_cmd;

    hlct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req),
        .o_push(push), .o_cmd(f_cmd), .i_full(full));

    hlct_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(f_cmd),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_cmd(b_cmd));

    hlct_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_cmd(b_cmd),
        .o_pop(pop), .rsp(rsp));
endmodule
